// ===== hw/rtl/ygk_pkg.sv =====
// shared types, constants and saturating helpers for the yaw rate / gyro bias filter
package ygk_pkg;

  localparam int FRAC_BITS_DEF = 48;
  localparam int FRAC_BITS_MIN = 32;
  localparam int FRAC_BITS_MAX = 56;

  localparam logic [63:0] NS_PER_SEC = 64'd1000000000;
  localparam logic [63:0] S64_MAX = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;

  localparam logic [1:0] KIND_GYRO = 2'd0;
  localparam logic [1:0] KIND_ODO = 2'd1;

  localparam logic [1:0] REG_Q_RATE = 2'd0;
  localparam logic [1:0] REG_Q_BIAS = 2'd1;
  localparam logic [1:0] REG_R_GYRO = 2'd2;
  localparam logic [1:0] REG_ODO_SCALE = 2'd3;

  typedef struct packed {
    logic         start;
    logic [63:0]  a;
    logic [63:0]  b;
    logic [127:0] addend;
  } mul_req_t;

  typedef struct packed {
    logic        start;
    logic [63:0] x;
    logic [63:0] d;
  } div_req_t;

  function automatic logic [63:0] sadd(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic [63:0] ssub(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic [63:0] mag(input logic [63:0] a);
    return a[63] ? (~a + 64'd1) : a;
  endfunction

endpackage

// ===== hw/rtl/yaw_rate_gyro_bias_kalman.sv =====
// top level: two-state yaw rate / gyro bias kalman filter with a shared mul and div sequencer
// one item in flight: the next item is taken once each result is presented, later if the output stalls
// each divide (time step, two gains) and each multiply holds the sequencer until its unit signals done
// reset: rst synchronous, restores registers, estimates, covariance and clears the clock
module yaw_rate_gyro_bias_kalman #(
  parameter int FRAC_BITS = ygk_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          kind,
  input  logic [63:0]         timestamp_ns,
  input  logic signed [31:0]  measurement,
  input  logic [31:0]         rot_std,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [63:0]  yaw_rate_est,
  output logic signed [63:0]  gyro_bias_est,
  output logic                updated,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [63:0]         cfg_data
);
  import ygk_pkg::*;

  localparam logic [63:0] ONE_Q = 64'd1 << FRAC_BITS;
  localparam logic [63:0] Q_RATE_RST = (ONE_Q + 64'd50) / 64'd100;
  localparam logic [63:0] Q_BIAS_RST = (ONE_Q + 64'd200000000) / 64'd400000000;
  localparam logic [63:0] R_GYRO_RST = (ONE_Q + 64'd200) / 64'd400;
  localparam logic [127:0] ROUND_HALF = 128'd1 << (FRAC_BITS - 1);
  localparam int ODO_SHL = (FRAC_BITS >= 48) ? FRAC_BITS - 48 : 0;
  localparam int ODO_SHR = (FRAC_BITS >= 48) ? 0 : 48 - FRAC_BITS;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ODO1  = 4'd1;
  localparam logic [3:0] S_ODO2  = 4'd2;
  localparam logic [3:0] S_DT    = 4'd3;
  localparam logic [3:0] S_PQ0   = 4'd4;
  localparam logic [3:0] S_PQ1   = 4'd5;
  localparam logic [3:0] S_COMB  = 4'd6;
  localparam logic [3:0] S_INNOV = 4'd7;
  localparam logic [3:0] S_SVAR  = 4'd8;
  localparam logic [3:0] S_CHK   = 4'd9;
  localparam logic [3:0] S_K0    = 4'd10;
  localparam logic [3:0] S_K1    = 4'd11;
  localparam logic [3:0] S_UPD   = 4'd12;
  localparam logic [3:0] S_FIN   = 4'd13;

  logic [3:0]  state;
  logic        pend;
  logic [2:0]  ustep;

  logic [62:0] q_rate;
  logic [62:0] q_bias;
  logic [62:0] r_gyro;
  logic [15:0] odo_scale;

  logic [63:0] rate;
  logic [63:0] bias;
  logic [63:0] p0, p1, p2, p3;
  logic [63:0] last_time;
  logic        clk_started;

  logic        gyro;
  logic [63:0] dtns;
  logic [63:0] meas_eff;
  logic [31:0] rot;
  logic [63:0] rot2;
  logic [63:0] r_val;
  logic [63:0] dt;
  logic [63:0] cp0, cp1, pc0, pc1, cx;
  logic [63:0] y;
  logic [63:0] sv;
  logic [63:0] k0, k1;
  logic        upd;

  mul_req_t     mreq;
  div_req_t     dreq;
  logic         mdone;
  logic [127:0] prod;
  logic         ddone;
  logic [63:0]  quo;
  logic         qsat;

  logic [63:0] opa, opb;
  logic        neg;
  logic [63:0] mulq_res;
  logic [63:0] divq_res;
  logic [63:0] odo_res;
  logic [127:0] odo_sh;
  logic [63:0] prev;
  logic [63:0] scaled;
  logic        start;

  ygk_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mreq),
    .done (mdone),
    .prod (prod)
  );

  ygk_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (dreq),
    .done (ddone),
    .quo  (quo),
    .sat  (qsat)
  );

  assign in_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign start = !pend;

  // operand selection for the shared units
  always_comb begin
    opa = k0;
    opb = y;
    case (state)
      S_PQ0: begin
        opa = dt;
        opb = {1'b0, q_rate};
      end
      S_PQ1: begin
        opa = dt;
        opb = {1'b0, q_bias};
      end
      S_K0: begin
        opa = pc0;
        opb = sv;
      end
      S_K1: begin
        opa = pc1;
        opb = sv;
      end
      S_UPD: begin
        if (ustep == 3'd1) opa = k1;
        else if (ustep >= 3'd4) opa = k1;
        else opa = k0;
        if (ustep < 3'd2) opb = y;
        else opb = ustep[0] ? cp1 : cp0;
      end
      default: begin
        opa = k0;
        opb = y;
      end
    endcase
    neg = opa[63] ^ opb[63];

    mreq.start = 1'b0;
    mreq.a = mag(opa);
    mreq.b = mag(opb);
    mreq.addend = ROUND_HALF;
    if (state == S_ODO1) begin
      mreq.a = {32'd0, rot};
      mreq.b = {32'd0, rot};
      mreq.addend = 128'd0;
    end else if (state == S_ODO2) begin
      mreq.a = rot2;
      mreq.b = {48'd0, odo_scale};
      mreq.addend = 128'd0;
    end
    if (state == S_ODO1 || state == S_ODO2 || state == S_PQ0 || state == S_PQ1 ||
        state == S_UPD) begin
      mreq.start = start;
    end

    dreq.start = 1'b0;
    dreq.x = mag(opa);
    dreq.d = mag(opb);
    if (state == S_DT) begin
      dreq.x = dtns;
      dreq.d = NS_PER_SEC;
      dreq.start = start;
    end else if (state == S_K0 || state == S_K1) begin
      dreq.start = start;
    end
  end

  // rounding product and quotient back to signed fixed point
  always_comb begin
    if (|prod[127:FRAC_BITS+63]) mulq_res = neg ? S64_MIN : S64_MAX;
    else if (neg) mulq_res = ~{1'b0, prod[FRAC_BITS+62:FRAC_BITS]} + 64'd1;
    else mulq_res = {1'b0, prod[FRAC_BITS+62:FRAC_BITS]};

    if (qsat || quo[63]) divq_res = neg ? S64_MIN : S64_MAX;
    else if (neg) divq_res = ~quo + 64'd1;
    else divq_res = quo;

    odo_sh = (prod << ODO_SHL) >> ODO_SHR;
    if (|(prod >> (111 - FRAC_BITS))) odo_res = S64_MAX;
    else odo_res = odo_sh[63:0];

    prev = clk_started ? last_time : timestamp_ns;
    scaled = {{32{measurement[31]}}, measurement} << (FRAC_BITS - 24);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pend <= 1'b0;
      ustep <= 3'd0;
      q_rate <= Q_RATE_RST[62:0];
      q_bias <= Q_BIAS_RST[62:0];
      r_gyro <= R_GYRO_RST[62:0];
      odo_scale <= 16'd250;
      rate <= 64'd0;
      bias <= 64'd0;
      p0 <= ONE_Q;
      p1 <= 64'd0;
      p2 <= 64'd0;
      p3 <= R_GYRO_RST;
      last_time <= 64'd0;
      clk_started <= 1'b0;
      out_valid <= 1'b0;
      upd <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_Q_RATE: q_rate <= cfg_data[62:0];
          REG_Q_BIAS: q_bias <= cfg_data[62:0];
          REG_R_GYRO: r_gyro <= cfg_data[62:0];
          REG_ODO_SCALE: odo_scale <= cfg_data[15:0];
          default: odo_scale <= odo_scale;
        endcase
      end
      if (out_valid && out_ready) out_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            clk_started <= 1'b1;
            upd <= 1'b0;
            gyro <= (kind == KIND_GYRO);
            rot <= rot_std;
            dtns <= timestamp_ns - prev;
            meas_eff <= (kind == KIND_GYRO) ? ssub(64'd0, scaled) : scaled;
            r_val <= {1'b0, r_gyro};
            state <= S_FIN;
            if (kind == KIND_GYRO || kind == KIND_ODO) begin
              last_time <= timestamp_ns;
              if (timestamp_ns > prev) state <= (kind == KIND_ODO) ? S_ODO1 : S_DT;
            end else if (!clk_started) begin
              last_time <= timestamp_ns;
            end
          end
        end
        S_ODO1: begin
          pend <= 1'b1;
          if (pend && mdone) begin
            pend <= 1'b0;
            rot2 <= prod[63:0];
            state <= S_ODO2;
          end
        end
        S_ODO2: begin
          pend <= 1'b1;
          if (pend && mdone) begin
            pend <= 1'b0;
            r_val <= odo_res;
            state <= S_DT;
          end
        end
        S_DT: begin
          pend <= 1'b1;
          if (pend && ddone) begin
            pend <= 1'b0;
            dt <= (qsat || quo[63]) ? S64_MAX : quo;
            state <= S_PQ0;
          end
        end
        S_PQ0: begin
          pend <= 1'b1;
          if (pend && mdone) begin
            pend <= 1'b0;
            p0 <= sadd(p0, mulq_res);
            state <= S_PQ1;
          end
        end
        S_PQ1: begin
          pend <= 1'b1;
          if (pend && mdone) begin
            pend <= 1'b0;
            p3 <= sadd(p3, mulq_res);
            state <= S_COMB;
          end
        end
        S_COMB: begin
          cp0 <= gyro ? sadd(p0, p2) : p0;
          cp1 <= gyro ? sadd(p1, p3) : p1;
          pc0 <= gyro ? sadd(p0, p1) : p0;
          pc1 <= gyro ? sadd(p2, p3) : p2;
          cx <= gyro ? sadd(rate, bias) : rate;
          state <= S_INNOV;
        end
        S_INNOV: begin
          y <= ssub(meas_eff, cx);
          sv <= gyro ? sadd(cp0, cp1) : cp0;
          state <= S_SVAR;
        end
        S_SVAR: begin
          sv <= sadd(r_val, sv);
          state <= S_CHK;
        end
        S_CHK: begin
          // innovation variance must be positive for a gain step
          state <= (sv[63] || sv == 64'd0) ? S_FIN : S_K0;
        end
        S_K0: begin
          pend <= 1'b1;
          if (pend && ddone) begin
            pend <= 1'b0;
            k0 <= divq_res;
            state <= S_K1;
          end
        end
        S_K1: begin
          pend <= 1'b1;
          if (pend && ddone) begin
            pend <= 1'b0;
            k1 <= divq_res;
            ustep <= 3'd0;
            state <= S_UPD;
          end
        end
        S_UPD: begin
          pend <= 1'b1;
          if (pend && mdone) begin
            pend <= 1'b0;
            ustep <= ustep + 3'd1;
            case (ustep)
              3'd0: rate <= sadd(rate, mulq_res);
              3'd1: bias <= sadd(bias, mulq_res);
              3'd2: p0 <= ssub(p0, mulq_res);
              3'd3: p1 <= ssub(p1, mulq_res);
              3'd4: p2 <= ssub(p2, mulq_res);
              default: p3 <= ssub(p3, mulq_res);
            endcase
            if (ustep == 3'd5) begin
              upd <= 1'b1;
              state <= S_FIN;
            end
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (state == S_FIN && (!out_valid || out_ready)) begin
      yaw_rate_est <= rate;
      gyro_bias_est <= bias;
      updated <= upd;
    end
  end

endmodule

// ===== hw/rtl/ygk_mul.sv =====
// 64x64 unsigned multiply-accumulate built from four 32x32 partial products
module ygk_mul (
  input  logic               clk,
  input  logic               rst,
  input  ygk_pkg::mul_req_t  req,
  output logic               done,
  output logic [127:0]       prod
);
  import ygk_pkg::*;

  logic         busy;
  logic [1:0]   step;
  logic [63:0]  a;
  logic [63:0]  b;
  logic [127:0] acc;
  logic [31:0]  pa;
  logic [31:0]  pb;
  logic [63:0]  pp;
  logic [127:0] pp_sh;

  always_comb begin
    pa = step[1] ? a[63:32] : a[31:0];
    pb = step[0] ? b[63:32] : b[31:0];
    pp = pa * pb;
    case (step)
      2'd0: pp_sh = {64'd0, pp};
      2'd1, 2'd2: pp_sh = {32'd0, pp, 32'd0};
      default: pp_sh = {pp, 64'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= 2'd0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= 2'd0;
      end else if (busy) begin
        step <= step + 2'd1;
        if (step == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a <= req.a;
      b <= req.b;
      acc <= req.addend;
    end else if (busy) begin
      acc <= acc + pp_sh;
    end
  end

  assign prod = acc;

endmodule

// ===== hw/rtl/ygk_div.sv =====
// radix-2 restoring divider: (x << frac) / d, one quotient bit per cycle
module ygk_div #(
  parameter int FRAC_BITS = ygk_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  ygk_pkg::div_req_t  req,
  output logic               done,
  output logic [63:0]        quo,
  output logic               sat
);
  import ygk_pkg::*;

  logic         busy;
  logic [6:0]   cnt;
  logic [63:0]  rem;
  logic [63:0]  nlo;
  logic [63:0]  d;
  logic [127:0] num;
  logic [64:0]  remx;
  logic         ge;

  always_comb begin
    num = {64'd0, req.x} << FRAC_BITS;
    remx = {rem, nlo[63]};
    ge = remx >= {1'b0, d};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= 7'd0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= 7'd64;
      end else if (busy) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= num[127:64];
      nlo <= num[63:0];
      d <= req.d;
      quo <= 64'd0;
      // quotient would not fit in 64 bits
      sat <= (req.d == 64'd0) || (num[127:64] >= req.d);
    end else if (busy) begin
      rem <= ge ? 64'(remx - {1'b0, d}) : remx[63:0];
      nlo <= {nlo[62:0], 1'b0};
      quo <= {quo[62:0], ge};
    end
  end

endmodule

// ===== hw/rtl/ygk_check.sv =====
// port-level checks for the yaw rate / gyro bias filter, bound to the top level
module ygk_check (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);

  // one item at a time: after an input beat the block is busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in flight");

  // a result appears only as the sequencer returns to idle
  a_result_at_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("result raised while sequencer busy");

  // a waiting result is held
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before its beat");

endmodule

bind yaw_rate_gyro_bias_kalman ygk_check u_ygk_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready)
);
